// ----- hdl/pwpm_pkg.sv -----
// shared types and constants of the priority weighted point merge unit
// no dependencies; compiled first
package pwpm_pkg;

  // used bits of the coordinate and area fields
  localparam int COORD_BITS = 24;
  localparam int AREA_BITS  = 24;

  // fixed field widths
  localparam int CW   = 24;
  localparam int AW   = 24;
  localparam int PW   = 16;
  localparam int SUMW = 40;
  localparam int WSW  = 64;
  localparam int PRODW = CW + AW + 1;

  // decoupling queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTRW  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  // divider steps, one quotient bit each
  localparam int DIV_STEPS = WSW;
  localparam int DCNTW     = $clog2(DIV_STEPS);

  // coordinate clamp limits
  localparam logic [WSW-1:0] COORD_MAX     = WSW'((65'd1 << (COORD_BITS - 1)) - 65'd1);
  localparam logic [WSW:0]   COORD_MIN_MAG = (WSW + 1)'(65'd1 << (COORD_BITS - 1));
  localparam logic [CW-1:0]  COORD_MAX_CODE = COORD_MAX[CW-1:0];
  localparam logic [CW-1:0]  COORD_MIN_CODE = ~COORD_MAX[CW-1:0];

  localparam logic [SUMW-1:0] SUM40_MAX = '1;

  // classified point handed from front to back
  typedef struct packed {
    logic signed [CW-1:0] coord;
    logic [AW-1:0]        area;
    logic [AW-1:0]        weight;
    logic [PW-1:0]        prio;
    logic                 last;
  } point_t;

endpackage

// ----- hdl/pwpm_if.sv -----
// channel interfaces of the point merge unit: point input and group result
// depends on pwpm_pkg
interface pwpm_in_if import pwpm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] coord;
  logic [AW-1:0]        area;
  logic [PW-1:0]        priority_req;
  logic                 last_point;

  modport source (output valid, coord, area, priority_req, last_point, input ready);
  modport sink   (input valid, coord, area, priority_req, last_point, output ready);
endinterface

interface pwpm_out_if import pwpm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] group_coord;
  logic [SUMW-1:0]      group_area;
  logic [PW-1:0]        group_priority;
  logic                 last_group;

  modport source (output valid, group_coord, group_area, group_priority, last_group,
                  input ready);
  modport sink   (input valid, group_coord, group_area, group_priority, last_group,
                  output ready);
endinterface

// ----- hdl/pwpm_front.sv -----
// front end: accepts points, trims fields to their used width, derives the weight
// depends on pwpm_pkg and pwpm_if
module pwpm_front import pwpm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  pwpm_in_if.sink   in_pt,
  output logic      q_wr_valid,
  input  logic      q_wr_ready,
  output point_t    q_wr_data
);

  logic   vld_r, vld_nxt;
  point_t pkt_r, pkt_nxt;
  logic   take;
  logic [AW-1:0] area_c;

  assign in_pt.ready = !vld_r || q_wr_ready;
  assign take        = in_pt.valid && in_pt.ready;

  // field trimming and weight classification
  always_comb begin
    area_c        = AW'(in_pt.area[AREA_BITS-1:0]);
    pkt_nxt.coord = CW'($signed(in_pt.coord[COORD_BITS-1:0]));
    pkt_nxt.area  = area_c;
    pkt_nxt.weight = (area_c == '0) ? AW'(1) : area_c;
    pkt_nxt.prio  = in_pt.priority_req;
    pkt_nxt.last  = in_pt.last_point;
  end

  always_comb begin
    vld_nxt = vld_r;
    if (take) begin
      vld_nxt = 1'b1;
    end else if (q_wr_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    if (take) begin
      pkt_r <= pkt_nxt;
    end
  end

  assign q_wr_valid = vld_r;
  assign q_wr_data  = pkt_r;

endmodule

// ----- hdl/pwpm_queue.sv -----
// short point queue decoupling the front end from the merge engine
// depends on pwpm_pkg
module pwpm_queue import pwpm_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   wr_valid,
  output logic   wr_ready,
  input  point_t wr_data,
  output logic   rd_valid,
  input  logic   rd_ready,
  output point_t rd_data
);

  localparam int CNTW = $clog2(QDEPTH + 1);

  point_t            mem_r [QDEPTH];
  logic [QPTRW-1:0]  wp_r, rp_r;
  logic [CNTW-1:0]   cnt_r;
  logic              push, pop;

  assign wr_ready = (cnt_r != CNTW'(QDEPTH));
  assign rd_valid = (cnt_r != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = mem_r[rp_r];

  // pointers wrap at the queue depth
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == QPTRW'(QDEPTH - 1)) ? '0 : wp_r + QPTRW'(1);
      end
      if (pop) begin
        rp_r <= (rp_r == QPTRW'(QDEPTH - 1)) ? '0 : rp_r + QPTRW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CNTW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CNTW'(1);
      end
    end
    if (push) begin
      mem_r[wp_r] <= wr_data;
    end
  end

endmodule

// ----- hdl/pwpm_back.sv -----
// merge engine: distance test, group sums, bit-serial center division, result register
// depends on pwpm_pkg and pwpm_if
module pwpm_back import pwpm_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_wr_en,
  input  logic [CW-1:0]   cfg_wr_data,
  input  logic            q_rd_valid,
  output logic            q_rd_ready,
  input  point_t          q_rd_data,
  pwpm_out_if.source      out_grp
);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_UPD, S_DSET, S_DIV, S_FIN, S_LAST
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CW-1:0]           tol_r;
  point_t                  cur_r, cur_nxt;
  logic signed [PRODW-1:0] prod_r, prod_nxt;
  logic                    merge_r, merge_nxt;
  logic                    open_r, open_nxt;
  logic [SUMW-1:0]         tarea_r, tarea_nxt;
  logic [PW-1:0]           tprio_r, tprio_nxt;
  logic signed [WSW-1:0]   wsum_r, wsum_nxt;
  logic [SUMW-1:0]         warea_r, warea_nxt;
  logic signed [CW-1:0]    center_r, center_nxt;
  logic [WSW-1:0]          dq_r, dq_nxt;
  logic [SUMW-1:0]         rem_r, rem_nxt;
  logic [DCNTW-1:0]        cnt_r, cnt_nxt;
  logic                    neg_r, neg_nxt;
  logic                    ovld_r, ovld_nxt;
  logic signed [CW-1:0]    ocoord_r, ocoord_nxt;
  logic [SUMW-1:0]         oarea_r, oarea_nxt;
  logic [PW-1:0]           oprio_r, oprio_nxt;
  logic                    olast_r, olast_nxt;

  logic [CW:0]      diff, dist_mag;
  logic [WSW-1:0]   prod_ext;
  logic [WSW:0]     wadd;
  logic [SUMW:0]    tadd, aadd;
  logic [SUMW:0]    trial;
  logic [WSW:0]     qmag;
  logic [WSW:0]     qneg;
  logic             out_free;

  assign out_free   = !ovld_r || out_grp.ready;
  assign q_rd_ready = (state_r == S_IDLE);

  // datapath helpers
  always_comb begin
    diff     = {cur_r.coord[CW-1], cur_r.coord} - {center_r[CW-1], center_r};
    dist_mag = diff[CW] ? (~diff + (CW + 1)'(1)) : diff;
    prod_ext = WSW'(prod_r);
    wadd     = {wsum_r[WSW-1], wsum_r} + {prod_ext[WSW-1], prod_ext};
    tadd     = {1'b0, tarea_r} + (SUMW + 1)'(cur_r.area);
    aadd     = {1'b0, warea_r} + (SUMW + 1)'(cur_r.weight);
    trial    = {rem_r, dq_r[WSW-1]};
    qmag     = {1'b0, dq_r} + (WSW + 1)'(rem_r != '0);
    qneg     = ~qmag + (WSW + 1)'(1);
  end

  always_comb begin
    state_nxt  = state_r;
    cur_nxt    = cur_r;
    prod_nxt   = prod_r;
    merge_nxt  = merge_r;
    open_nxt   = open_r;
    tarea_nxt  = tarea_r;
    tprio_nxt  = tprio_r;
    wsum_nxt   = wsum_r;
    warea_nxt  = warea_r;
    center_nxt = center_r;
    dq_nxt     = dq_r;
    rem_nxt    = rem_r;
    cnt_nxt    = cnt_r;
    neg_nxt    = neg_r;
    ovld_nxt   = ovld_r && !out_grp.ready;
    ocoord_nxt = ocoord_r;
    oarea_nxt  = oarea_r;
    oprio_nxt  = oprio_r;
    olast_nxt  = olast_r;

    case (state_r)
      // fetch the next point from the queue
      S_IDLE: begin
        if (q_rd_valid) begin
          cur_nxt   = q_rd_data;
          state_nxt = S_MUL;
        end
      end
      // coordinate times weight, distance test against the group center
      S_MUL: begin
        prod_nxt  = cur_r.coord * $signed({1'b0, cur_r.weight});
        merge_nxt = open_r && (dist_mag <= {1'b0, tol_r});
        state_nxt = S_UPD;
      end
      // update group sums, or close the group and start a new one
      S_UPD: begin
        if (merge_r) begin
          tarea_nxt = tadd[SUMW] ? SUM40_MAX : tadd[SUMW-1:0];
          if (cur_r.prio > tprio_r) begin
            tprio_nxt = cur_r.prio;
            wsum_nxt  = prod_ext;
            warea_nxt = SUMW'(cur_r.weight);
          end else if (cur_r.prio == tprio_r) begin
            if (wadd[WSW] != wadd[WSW-1]) begin
              wsum_nxt = wadd[WSW] ? {1'b1, {(WSW-1){1'b0}}} : {1'b0, {(WSW-1){1'b1}}};
            end else begin
              wsum_nxt = wadd[WSW-1:0];
            end
            warea_nxt = aadd[SUMW] ? SUM40_MAX : aadd[SUMW-1:0];
          end
          state_nxt = S_DSET;
        end else if (!open_r || out_free) begin
          if (open_r) begin
            ovld_nxt   = 1'b1;
            ocoord_nxt = center_r;
            oarea_nxt  = tarea_r;
            oprio_nxt  = tprio_r;
            olast_nxt  = 1'b0;
          end
          open_nxt  = 1'b1;
          tarea_nxt = SUMW'(cur_r.area);
          tprio_nxt = cur_r.prio;
          wsum_nxt  = prod_ext;
          warea_nxt = SUMW'(cur_r.weight);
          state_nxt = S_DSET;
        end
      end
      // load the divider with the magnitude of the weighted sum
      S_DSET: begin
        neg_nxt   = wsum_r[WSW-1];
        dq_nxt    = wsum_r[WSW-1] ? (~wsum_r + WSW'(1)) : wsum_r;
        rem_nxt   = '0;
        cnt_nxt   = DCNTW'(DIV_STEPS - 1);
        state_nxt = S_DIV;
      end
      // restoring division, one quotient bit per cycle
      S_DIV: begin
        if (trial >= {1'b0, warea_r}) begin
          rem_nxt = SUMW'(trial - {1'b0, warea_r});
          dq_nxt  = {dq_r[WSW-2:0], 1'b1};
        end else begin
          rem_nxt = trial[SUMW-1:0];
          dq_nxt  = {dq_r[WSW-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - DCNTW'(1);
        if (cnt_r == '0) begin
          state_nxt = S_FIN;
        end
      end
      // floor toward minus infinity, clamp to the coordinate range
      S_FIN: begin
        if (neg_r) begin
          center_nxt = (qmag > COORD_MIN_MAG) ? COORD_MIN_CODE : qneg[CW-1:0];
        end else begin
          center_nxt = (dq_r > COORD_MAX) ? COORD_MAX_CODE : dq_r[CW-1:0];
        end
        state_nxt = cur_r.last ? S_LAST : S_IDLE;
      end
      // flush the open group on the last point
      S_LAST: begin
        if (out_free) begin
          ovld_nxt   = 1'b1;
          ocoord_nxt = center_r;
          oarea_nxt  = tarea_r;
          oprio_nxt  = tprio_r;
          olast_nxt  = 1'b1;
          open_nxt   = 1'b0;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      tol_r    <= '0;
      open_r   <= 1'b0;
      merge_r  <= 1'b0;
      tarea_r  <= '0;
      tprio_r  <= '0;
      wsum_r   <= '0;
      warea_r  <= '0;
      center_r <= '0;
      cnt_r    <= '0;
      ovld_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      if (cfg_wr_en) begin
        tol_r <= cfg_wr_data;
      end
      open_r   <= open_nxt;
      merge_r  <= merge_nxt;
      tarea_r  <= tarea_nxt;
      tprio_r  <= tprio_nxt;
      wsum_r   <= wsum_nxt;
      warea_r  <= warea_nxt;
      center_r <= center_nxt;
      cnt_r    <= cnt_nxt;
      ovld_r   <= ovld_nxt;
    end
    cur_r    <= cur_nxt;
    prod_r   <= prod_nxt;
    dq_r     <= dq_nxt;
    rem_r    <= rem_nxt;
    neg_r    <= neg_nxt;
    ocoord_r <= ocoord_nxt;
    oarea_r  <= oarea_nxt;
    oprio_r  <= oprio_nxt;
    olast_r  <= olast_nxt;
  end

  assign out_grp.valid          = ovld_r;
  assign out_grp.group_coord    = ocoord_r;
  assign out_grp.group_area     = oarea_r;
  assign out_grp.group_priority = oprio_r;
  assign out_grp.last_group     = olast_r;

`ifndef SYNTHESIS
  // an open group always has a nonzero divisor
  a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    open_r |-> (warea_r != '0))
    else $error("open group with zero weight sum");

  // the divider runs until its count is spent
  a_div_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && cnt_r != '0) |=> (state_r == S_DIV))
    else $error("divider left early");

  // a pending result is never dropped by the engine
  a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (ovld_r && !out_grp.ready) |=> (ovld_r && $stable(olast_r)))
    else $error("pending result overwritten");
`endif

endmodule

// ----- hdl/priority_weighted_point_merge_unit.sv -----
// top level of the priority weighted point merge unit
// depends on pwpm_pkg, pwpm_if, pwpm_front, pwpm_queue, pwpm_back
//
// Points sorted by coordinate enter on in_pt; a point within cfg tolerance of the
// running group center joins the group, any other point closes it and the closed
// group leaves on out_grp, the last point flushes the open group. Each point passes
// through the merge engine's steps in order (fetch, multiply, update, divider load, 64
// divide steps, finish), plus a flush step when it is the last point; the group center
// comes from the bit-serial 64 by 40 bit division, one quotient bit per cycle.
// A two-entry queue and a front register take new points while the engine works,
// and a result register holds a finished group until it is taken.
module priority_weighted_point_merge_unit import pwpm_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_wr_en,
  input  logic [CW-1:0] cfg_wr_data,
  pwpm_in_if.sink       in_pt,
  pwpm_out_if.source    out_grp
);

  logic   qw_valid, qw_ready, qr_valid, qr_ready;
  point_t qw_data, qr_data;

  pwpm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_pt      (in_pt),
    .q_wr_valid (qw_valid),
    .q_wr_ready (qw_ready),
    .q_wr_data  (qw_data)
  );

  pwpm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (qw_valid),
    .wr_ready (qw_ready),
    .wr_data  (qw_data),
    .rd_valid (qr_valid),
    .rd_ready (qr_ready),
    .rd_data  (qr_data)
  );

  pwpm_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_rd_valid  (qr_valid),
    .q_rd_ready  (qr_ready),
    .q_rd_data   (qr_data),
    .out_grp     (out_grp)
  );

endmodule
